// ----- hdl/rbst_pkg.sv -----
// ============================================================================
// rbst_pkg
// Shared word types for the ray versus axis-aligned box slab test.
// ============================================================================
`default_nettype none

package rbst_pkg;

	localparam int unsigned FIELD_BITS = 32;
	localparam int unsigned DIST_BITS  = 31;
	localparam int unsigned THR_BITS   = 16;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] origin_x;
		logic signed [FIELD_BITS-1:0] origin_y;
		logic signed [FIELD_BITS-1:0] origin_z;
		logic signed [FIELD_BITS-1:0] dir_x;
		logic signed [FIELD_BITS-1:0] dir_y;
		logic signed [FIELD_BITS-1:0] dir_z;
		logic signed [FIELD_BITS-1:0] lo_x;
		logic signed [FIELD_BITS-1:0] lo_y;
		logic signed [FIELD_BITS-1:0] lo_z;
		logic signed [FIELD_BITS-1:0] hi_x;
		logic signed [FIELD_BITS-1:0] hi_y;
		logic signed [FIELD_BITS-1:0] hi_z;
	} ray_word_t;

	typedef struct packed {
		logic                 hit;
		logic [DIST_BITS-1:0] distance;
	} res_word_t;

endpackage

`default_nettype wire

// ----- hdl/rbst_in_if.sv -----
// ============================================================================
// rbst_in_if
// Valid/ready channel that carries one ray and box word.
// ============================================================================
`default_nettype none

interface rbst_in_if;
	logic                valid;
	logic                ready;
	rbst_pkg::ray_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/rbst_out_if.sv -----
// ============================================================================
// rbst_out_if
// Valid/ready channel that carries one hit and distance word.
// ============================================================================
`default_nettype none

interface rbst_out_if;
	logic                valid;
	logic                ready;
	rbst_pkg::res_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ray_box_slab_test.sv -----
// ============================================================================
// ray_box_slab_test
// Ray versus axis-aligned box, slab method, signed Q16.16, fully pipelined.
// ============================================================================
// The block takes one ray/box word per cycle while the output word is taken and
// returns one result word per word, in order.
// The six slab distances are computed by six restoring dividers unrolled into
// one pipeline stage per quotient bit; that divider chain sets the latency. All
// stages advance together and hold only when the output word is not taken.
`default_nettype none

module ray_box_slab_test #(
	parameter int COORD_BITS = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [rbst_pkg::THR_BITS-1:0] cfg_wdata,
	rbst_in_if.sink                      ray,
	rbst_out_if.source                   res
);

	localparam int IW = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int DW = IW + 17;   // dividend and quotient width
	localparam int TW = DW + 1;    // signed distance width
	localparam logic signed [TW-1:0] T_FAR  = {1'b0, {DW{1'b1}}};
	localparam logic signed [TW-1:0] D_MAX  =
		TW'({1'b0, {rbst_pkg::DIST_BITS{1'b1}}});

	logic [rbst_pkg::THR_BITS-1:0] thr_q;
	logic                          en;
	logic                          ov_q;
	rbst_pkg::res_word_t           od_q;

	assign en        = !ov_q || res.ready;
	assign ray.ready = en;
	assign res.valid = ov_q;
	assign res.data  = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rbst_pkg::THR_BITS'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Stage 1: slab plane offsets, direction magnitude, parallel test.
	logic [2:0][IW:0]        dlo_s1, dhi_s1;
	logic [2:0][IW-1:0]      den_s1;
	logic [2:0]              dneg_s1, par_s1;
	logic                    outside_s1;
	logic                    v_s1;

	logic [2:0][IW:0]        c_dlo, c_dhi;
	logic [2:0][IW-1:0]      c_den;
	logic [2:0]              c_dneg, c_par;
	logic                    c_outside;

	always_comb begin
		logic signed [IW-1:0] o, d, lo, hi;
		logic [IW-1:0]        md;
		c_outside = 1'b0;
		for (int a = 0; a < 3; a++) begin
			case (a)
				0: begin
					o = ray.data.origin_x[IW-1:0]; d = ray.data.dir_x[IW-1:0];
					lo = ray.data.lo_x[IW-1:0]; hi = ray.data.hi_x[IW-1:0];
				end
				1: begin
					o = ray.data.origin_y[IW-1:0]; d = ray.data.dir_y[IW-1:0];
					lo = ray.data.lo_y[IW-1:0]; hi = ray.data.hi_y[IW-1:0];
				end
				default: begin
					o = ray.data.origin_z[IW-1:0]; d = ray.data.dir_z[IW-1:0];
					lo = ray.data.lo_z[IW-1:0]; hi = ray.data.hi_z[IW-1:0];
				end
			endcase
			md        = d[IW-1] ? IW'(-d) : IW'(d);
			c_den[a]  = md;
			c_dneg[a] = d[IW-1];
			c_par[a]  = (md == '0) || (md < IW'(thr_q));
			c_dlo[a]  = (IW+1)'({lo[IW-1], lo} - {o[IW-1], o});
			c_dhi[a]  = (IW+1)'({hi[IW-1], hi} - {o[IW-1], o});
			if (c_par[a] && ((o < lo) || (o > hi))) begin
				c_outside = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlo_s1     <= c_dlo;
			dhi_s1     <= c_dhi;
			den_s1     <= c_den;
			dneg_s1    <= c_dneg;
			par_s1     <= c_par;
			outside_s1 <= c_outside;
		end
	end

	// Divider pipeline: index 0 is loaded by stage 2, one quotient bit per
	// stage after that. Even lanes divide the low plane, odd lanes the high.
	logic                      v_sd    [0:DW];
	logic [5:0][IW-1:0]        rem_sd  [0:DW];
	logic [5:0][DW-1:0]        quo_sd  [0:DW];
	logic [2:0][IW-1:0]        den_sd  [0:DW];
	logic [5:0]                neg_sd  [0:DW];
	logic [2:0]                par_sd  [0:DW];
	logic                      out_sd  [0:DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				logic [IW:0] df;
				df = i[0] ? dhi_s1[i/2] : dlo_s1[i/2];
				rem_sd[0][i] <= '0;
				quo_sd[0][i] <= {(df[IW] ? (IW+1)'(-df) : df), 16'b0};
				neg_sd[0][i] <= df[IW] ^ dneg_s1[i/2];
			end
			den_sd[0] <= den_s1;
			par_sd[0] <= par_s1;
			out_sd[0] <= outside_s1;
		end
	end

	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [5:0][IW-1:0] rem_nx;
		logic [5:0][DW-1:0] quo_nx;

		always_comb begin
			logic [IW:0]   r2;
			logic [IW+1:0] df;
			for (int i = 0; i < 6; i++) begin
				r2 = {rem_sd[k][i], quo_sd[k][i][DW-1]};
				df = {1'b0, r2} - {2'b0, den_sd[k][i/2]};
				rem_nx[i] = df[IW+1] ? r2[IW-1:0] : df[IW-1:0];
				quo_nx[i] = {quo_sd[k][i][DW-2:0], !df[IW+1]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (en) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k+1] <= rem_nx;
				quo_sd[k+1] <= quo_nx;
				den_sd[k+1] <= den_sd[k];
				neg_sd[k+1] <= neg_sd[k];
				par_sd[k+1] <= par_sd[k];
				out_sd[k+1] <= out_sd[k];
			end
		end
	end

	// Fold stages: sign, sort per axis, then max of entries and min of exits.
	logic                       v_f1, v_f2, v_f3;
	logic [5:0][TW-1:0]         t_f1;
	logic [2:0]                 par_f1;
	logic                       out_f1, out_f2, out_f3;
	logic [2:0][TW-1:0]         near_f2, far_f2;
	logic signed [TW-1:0]       ent_f3, ext_f3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
			v_f3 <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			v_f1 <= v_sd[DW];
			v_f2 <= v_f1;
			v_f3 <= v_f2;
			ov_q <= v_f3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				t_f1[i] <= neg_sd[DW][i] ? TW'(-{1'b0, quo_sd[DW][i]})
				                         : TW'({1'b0, quo_sd[DW][i]});
			end
			par_f1 <= par_sd[DW];
			out_f1 <= out_sd[DW];

			for (int a = 0; a < 3; a++) begin
				if (par_f1[a]) begin
					near_f2[a] <= '0;
					far_f2[a]  <= T_FAR;
				end else if ($signed(t_f1[2*a]) > $signed(t_f1[2*a+1])) begin
					near_f2[a] <= t_f1[2*a+1];
					far_f2[a]  <= t_f1[2*a];
				end else begin
					near_f2[a] <= t_f1[2*a];
					far_f2[a]  <= t_f1[2*a+1];
				end
			end
			out_f2 <= out_f1;
			out_f3 <= out_f2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [TW-1:0] n01, n2, f01;
		n01 = ($signed(near_f2[0]) > $signed(near_f2[1])) ? near_f2[0] : near_f2[1];
		n2  = ($signed(near_f2[2]) > 0) ? near_f2[2] : '0;
		f01 = ($signed(far_f2[0]) < $signed(far_f2[1])) ? far_f2[0] : far_f2[1];
		if (en) begin
			ent_f3 <= (n01 > n2) ? n01 : n2;
			ext_f3 <= ($signed(far_f2[2]) < f01) ? far_f2[2] : f01;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_f3 || (ent_f3 > ext_f3)) begin
				od_q.hit      <= 1'b0;
				od_q.distance <= '0;
			end else begin
				od_q.hit      <= 1'b1;
				od_q.distance <= (ent_f3 > D_MAX) ? {rbst_pkg::DIST_BITS{1'b1}}
				                 : ent_f3[rbst_pkg::DIST_BITS-1:0];
			end
		end
	end

endmodule

`default_nettype wire
